FILE: design/settable_clock_with_segment_scan_unit_defines.svh
// Assertion macros for the settable clock block.
// Both use the enclosing module's clk and rst.
`ifndef SETTABLE_CLOCK_WITH_SEGMENT_SCAN_UNIT_DEFINES_SVH
`define SETTABLE_CLOCK_WITH_SEGMENT_SCAN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSC_ASSERT_NOW(label, ante, cons, msg)
`define SSC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: design/ssc_pkg.sv
package ssc_pkg;

  localparam int unsigned CFG_W      = 8;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned NUM_DIGITS = 6;

  // register map, byte address 4*index
  typedef enum logic [1:0] {
    REG_PRESCALE   = 2'd0,
    REG_TENTHS     = 2'd1,
    REG_HOLD_SHORT = 2'd2,
    REG_HOLD_LONG  = 2'd3
  } reg_idx_t;

  // key code is the digit being scanned when the return line is high
  typedef enum logic [2:0] {
    KEY_ENTER = 3'd0,
    KEY_ESC   = 3'd1,
    KEY_RIGHT = 3'd2,
    KEY_UP    = 3'd3,
    KEY_DOWN  = 3'd4,
    KEY_LEFT  = 3'd5
  } key_t;

  localparam logic [1:0] FIELD_HOURS   = 2'd0;
  localparam logic [1:0] FIELD_MINUTES = 2'd1;
  localparam logic [1:0] FIELD_SECONDS = 2'd2;

  localparam logic [2:0] LAST_DIGIT = 3'(NUM_DIGITS - 1);

  localparam logic [CFG_W-1:0] RST_PRESCALE   = 8'd100;
  localparam logic [CFG_W-1:0] RST_TENTHS     = 8'd10;
  localparam logic [CFG_W-1:0] RST_HOLD_SHORT = 8'd180;
  localparam logic [CFG_W-1:0] RST_HOLD_LONG  = 8'd250;
  localparam logic [4:0]       RST_HOURS      = 5'd12;
  localparam logic [5:0]       RST_MINUTES    = 6'd43;
  localparam logic [5:0]       RST_SECONDS    = 6'd52;
  localparam logic [4:0]       MAX_HOUR       = 5'd23;
  localparam logic [5:0]       MAX_MINSEC     = 6'd59;
  localparam logic [7:0]       BLANK_PATTERN  = 8'hFF;

  typedef struct packed {
    logic [CFG_W-1:0] prescale_reload;
    logic [CFG_W-1:0] tenths_reload;
    logic [CFG_W-1:0] key_holdoff_short;
    logic [CFG_W-1:0] key_holdoff_long;
  } cfg_t;

  typedef struct packed {
    logic [5:0] digit_select;
    logic [7:0] segments;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       set_mode;
    logic [1:0] selected_field;
  } result_t;

  // gfedcba font
  function automatic logic [6:0] glyph(input logic [3:0] d);
    logic [6:0] g;
    unique case (d)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      default: g = 7'h3F;
    endcase
    return g;
  endfunction

  // tens digit of a value below 60
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    priority if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [2:0] t);
    logic [5:0] tenx;
    logic [5:0] diff;
    tenx = {t, 3'b000} + {2'b00, t, 1'b0};
    diff = v - tenx;
    return diff[3:0];
  endfunction

endpackage

FILE: design/ssc_in_if.sv
interface ssc_in_if;
  logic valid;
  logic ready;
  logic key_line;

  modport source (output valid, output key_line, input ready);
  modport sink   (input valid, input key_line, output ready);
endinterface

FILE: design/ssc_out_if.sv
interface ssc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_select;
  logic [7:0] segments;
  logic [4:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic       set_mode;
  logic [1:0] selected_field;

  modport source (output valid, output digit_select, output segments, output hours,
                  output minutes, output seconds, output set_mode,
                  output selected_field, input ready);
  modport sink   (input valid, input digit_select, input segments, input hours,
                  input minutes, input seconds, input set_mode,
                  input selected_field, output ready);
endinterface

FILE: design/ssc_cfg_regs.sv
module ssc_cfg_regs
  import ssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t   idx;
  logic       wr;
  logic [7:0] rd_byte;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prescale_reload   <= RST_PRESCALE;
      cfg.tenths_reload     <= RST_TENTHS;
      cfg.key_holdoff_short <= RST_HOLD_SHORT;
      cfg.key_holdoff_long  <= RST_HOLD_LONG;
    end else if (wr) begin
      unique case (idx)
        REG_PRESCALE:   cfg.prescale_reload   <= pwdata[CFG_W-1:0];
        REG_TENTHS:     cfg.tenths_reload     <= pwdata[CFG_W-1:0];
        REG_HOLD_SHORT: cfg.key_holdoff_short <= pwdata[CFG_W-1:0];
        REG_HOLD_LONG:  cfg.key_holdoff_long  <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRESCALE:   rd_byte = cfg.prescale_reload;
      REG_TENTHS:     rd_byte = cfg.tenths_reload;
      REG_HOLD_SHORT: rd_byte = cfg.key_holdoff_short;
      REG_HOLD_LONG:  rd_byte = cfg.key_holdoff_long;
    endcase
  end

  assign prdata = {{(APB_DATA_W-CFG_W){1'b0}}, rd_byte};

endmodule

FILE: design/ssc_engine.sv
module ssc_engine
  import ssc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  logic    key_line,
  input  cfg_t    cfg,
  output result_t res
);

  logic [4:0] hour_count, hour_adv, hour_count_next;
  logic [5:0] minute_count, minute_adv, minute_count_next;
  logic [5:0] second_count, second_adv, second_count_next;
  logic       stopped, stopped_next;
  logic [1:0] field_sel, field_sel_next;
  logic [7:0] holdoff_count, holdoff_count_next;
  logic       holdoff_pending, holdoff_pending_next;
  logic [7:0] prescale_count, prescale_count_next;
  logic [7:0] tenth_count, tenth_count_next, tenth_dec;
  logic       second_due, second_due_next;
  logic [2:0] scan_index, scan_index_next;
  logic       refreshed, refreshed_next;   // patterns no longer all lit

  logic       advance, press, mark;
  logic [1:0] pair;
  logic [5:0] digit_val;
  logic [2:0] tens;
  logic [3:0] digit;
  logic [7:0] seg;

  always_comb begin
    // holdoff
    holdoff_count_next   = holdoff_count;
    holdoff_pending_next = holdoff_pending;
    if (holdoff_count != 8'd0) begin
      holdoff_count_next = holdoff_count - 8'd1;
    end else if (holdoff_pending) begin
      holdoff_pending_next = 1'b0;
      holdoff_count_next   = cfg.key_holdoff_long;
    end

    // prescaler and tenths
    prescale_count_next = prescale_count;
    tenth_count_next    = tenth_count;
    second_due_next     = second_due;
    tenth_dec           = tenth_count - 8'd1;
    if (prescale_count != 8'd0) begin
      prescale_count_next = prescale_count - 8'd1;
    end else begin
      prescale_count_next = cfg.prescale_reload;
      if (tenth_dec == 8'd0) begin
        tenth_count_next = cfg.tenths_reload;
        second_due_next  = 1'b1;
      end else begin
        tenth_count_next = tenth_dec;
      end
    end

    // time of day
    hour_adv       = hour_count;
    minute_adv     = minute_count;
    second_adv     = second_count;
    refreshed_next = refreshed;
    advance        = second_due_next && !stopped;
    if (advance) begin
      second_due_next = 1'b0;
      refreshed_next  = 1'b1;
      if (second_count == MAX_MINSEC) begin
        second_adv = 6'd0;
        if (minute_count == MAX_MINSEC) begin
          minute_adv = 6'd0;
          hour_adv   = (hour_count == MAX_HOUR) ? 5'd0 : hour_count + 5'd1;
        end else begin
          minute_adv = minute_count + 6'd1;
        end
      end else begin
        second_adv = second_count + 6'd1;
      end
    end

    // display of the scanned digit
    pair = scan_index[2:1];
    unique case (pair)
      2'd0:    digit_val = second_adv;
      2'd1:    digit_val = minute_adv;
      default: digit_val = {1'b0, hour_adv};
    endcase
    tens  = tens_of(digit_val);
    digit = scan_index[0] ? {1'b0, tens} : ones_of(digit_val, tens);
    mark  = stopped && (pair == (FIELD_SECONDS - field_sel));
    seg   = refreshed_next ? {mark, glyph(digit)} : BLANK_PATTERN;

    // keys
    hour_count_next   = hour_adv;
    minute_count_next = minute_adv;
    second_count_next = second_adv;
    stopped_next      = stopped;
    field_sel_next    = field_sel;
    press             = key_line && (holdoff_count_next == 8'd0);
    if (press) begin
      refreshed_next     = 1'b1;
      holdoff_count_next = cfg.key_holdoff_short;
      unique case (key_t'(scan_index))
        KEY_ENTER: begin
          if (stopped) begin
            prescale_count_next = cfg.prescale_reload;
            tenth_count_next    = cfg.tenths_reload;
            stopped_next        = 1'b0;
            second_due_next     = 1'b0;
          end
        end
        KEY_ESC: stopped_next = 1'b1;
        KEY_RIGHT: begin
          holdoff_count_next   = cfg.key_holdoff_long;
          holdoff_pending_next = 1'b1;
          if (stopped)
            field_sel_next = (field_sel == FIELD_SECONDS) ? FIELD_HOURS : field_sel + 2'd1;
        end
        KEY_LEFT: begin
          holdoff_count_next   = cfg.key_holdoff_long;
          holdoff_pending_next = 1'b1;
          if (stopped)
            field_sel_next = (field_sel == FIELD_HOURS) ? FIELD_SECONDS : field_sel - 2'd1;
        end
        KEY_UP: begin
          if (stopped) begin
            priority case (field_sel)
              FIELD_HOURS:
                hour_count_next = (hour_adv == MAX_HOUR) ? 5'd0 : hour_adv + 5'd1;
              FIELD_MINUTES:
                minute_count_next = (minute_adv == MAX_MINSEC) ? 6'd0 : minute_adv + 6'd1;
              FIELD_SECONDS:
                second_count_next = (second_adv == MAX_MINSEC) ? 6'd0 : second_adv + 6'd1;
              default: ;
            endcase
          end
        end
        KEY_DOWN: begin
          if (stopped) begin
            priority case (field_sel)
              FIELD_HOURS:
                hour_count_next = (hour_adv == 5'd0) ? MAX_HOUR : hour_adv - 5'd1;
              FIELD_MINUTES:
                minute_count_next = (minute_adv == 6'd0) ? MAX_MINSEC : minute_adv - 6'd1;
              FIELD_SECONDS:
                second_count_next = (second_adv == 6'd0) ? MAX_MINSEC : second_adv - 6'd1;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end

    scan_index_next = (scan_index == LAST_DIGIT) ? 3'd0 : scan_index + 3'd1;

    res.digit_select   = 6'b000001 << scan_index;
    res.segments       = seg;
    res.hours          = hour_count_next;
    res.minutes        = minute_count_next;
    res.seconds        = second_count_next;
    res.set_mode       = stopped_next;
    res.selected_field = field_sel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count      <= RST_HOURS;
      minute_count    <= RST_MINUTES;
      second_count    <= RST_SECONDS;
      stopped         <= 1'b0;
      field_sel       <= FIELD_HOURS;
      holdoff_count   <= 8'd0;
      holdoff_pending <= 1'b0;
      prescale_count  <= RST_PRESCALE;
      tenth_count     <= RST_TENTHS;
      second_due      <= 1'b0;
      scan_index      <= 3'd0;
      refreshed       <= 1'b0;
    end else if (fire) begin
      hour_count      <= hour_count_next;
      minute_count    <= minute_count_next;
      second_count    <= second_count_next;
      stopped         <= stopped_next;
      field_sel       <= field_sel_next;
      holdoff_count   <= holdoff_count_next;
      holdoff_pending <= holdoff_pending_next;
      prescale_count  <= prescale_count_next;
      tenth_count     <= tenth_count_next;
      second_due      <= second_due_next;
      scan_index      <= scan_index_next;
      refreshed       <= refreshed_next;
    end
  end

endmodule

FILE: design/settable_clock_with_segment_scan_unit.sv
// Latency: a result appears in the cycle after its tick transaction is accepted.
// Throughput: one tick transaction per cycle while the result register is empty or being drained;
// all per-tick work is one level of logic between the clock state registers and the result register.
// Reset (rst, synchronous, active high): time 12:43:52, run mode, all patterns
// lit, config registers at 100/10/180/250, result register empty.
`include "settable_clock_with_segment_scan_unit_defines.svh"

module settable_clock_with_segment_scan_unit
  import ssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  ssc_in_if.sink                in_ch,
  ssc_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t res;       // result of the tick being accepted
  result_t res_q;     // result waiting at the output
  logic    out_valid;
  logic    fire;

  // Reload values and holdoff lengths; user must write them over APB only while idle (not enforced by the block).
  ssc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The output register frees up in the same cycle it is taken, so a new
  // tick is accepted whenever the slot is empty or being drained.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  // Clock state plus the per-tick next-state and display logic.
  ssc_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .key_line (in_ch.key_line),
    .cfg      (cfg),
    .res      (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.digit_select   = res_q.digit_select;
  assign out_ch.segments       = res_q.segments;
  assign out_ch.hours          = res_q.hours;
  assign out_ch.minutes        = res_q.minutes;
  assign out_ch.seconds        = res_q.seconds;
  assign out_ch.set_mode       = res_q.set_mode;
  assign out_ch.selected_field = res_q.selected_field;

  // Every accepted tick leaves a result behind it.
  `SSC_ASSERT_NEXT(a_tick_gives_result, fire, out_ch.valid, "accepted tick produced no result")
  // Exactly one digit is driven per result.
  `SSC_ASSERT_NOW(a_digit_onehot, out_ch.valid, $onehot(out_ch.digit_select), "digit select not one-hot")
  // Time and field selection stay in range.
  `SSC_ASSERT_NOW(a_time_range, out_ch.valid, (out_ch.hours < 5'd24) && (out_ch.minutes < 6'd60) && (out_ch.seconds < 6'd60) && (out_ch.selected_field != 2'd3), "time or field out of range")

endmodule
